// ===== hdl/csbc_pkg.sv =====
// Shared types and constants for the Caesar shift byte cipher.
// No dependencies; the design modules and the testbench import this package.
package csbc_pkg;

    localparam int QDEPTH = 3;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int LAT_W      = 5;
    localparam int CYR_W      = 6;
    localparam int DIG_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LATIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYRILLIC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT    = 2'd2;

    localparam logic [7:0] LEAD_D0 = 8'hD0;
    localparam logic [7:0] LEAD_D1 = 8'hD1;

    typedef enum logic {
        K_SINGLE = 1'b0,
        K_PAIR   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       d1;
        logic [7:0] data;
    } t_entry;

endpackage

// ===== hdl/csbc_in_if.sv =====
// Input byte channel: valid/ready handshake with byte and end-of-stream flag.
// No dependencies.
interface csbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== hdl/csbc_out_if.sv =====
// Output byte channel: valid/ready handshake with byte and last-of-run flag.
// No dependencies.
interface csbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hdl/caesar_shift_byte_cipher_top.sv =====
// Top level of the Caesar shift byte cipher: front end, work queue, back end.
// Depends on csbc_pkg, csbc_in_if, csbc_out_if, csbc_front, csbc_fifo, csbc_back.
//
//   channel  dir  payload                   handshake
//   i_in     in   in_byte, end_of_stream    valid/ready
//   o_out    out  out_byte, run_last        valid/ready
//   cfg      in   i_cfg_idx, i_cfg_data     i_cfg_we, no wait
//
// One input beat per cycle while the queue has room; a UTF-8 pair gives two output
// beats, and output runs at one beat per cycle while the receiver is ready. An
// accepted byte is registered in the queue and then in the output register.
// Synchronous active-low reset clears the held lead, queue, shift registers and
// output valid. Output stalls back up through the three-entry queue to i_in.ready.
module caesar_shift_byte_cipher_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [csbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    csbc_in_if.sink                           i_in,
    csbc_out_if.source                        o_out
);
    import csbc_pkg::*;

    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   head_valid;
    logic   head_pop;
    t_entry head;

    csbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    csbc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (head_valid),
        .i_pop_ready  (head_pop),
        .o_pop_entry  (head)
    );

    csbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .i_head       (head),
        .o_out        (o_out)
    );
endmodule

// ===== hdl/csbc_front.sv =====
// Front end: accepts input beats, holds UTF-8 lead bytes and queues work entries.
// Depends on csbc_pkg and csbc_in_if.
module csbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    csbc_in_if.sink           i_in,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output csbc_pkg::t_entry  o_push_entry
);
    import csbc_pkg::*;

    logic r_lead_pending;
    logic r_lead_d1;
    logic n_lead_pending;
    logic n_lead_d1;
    logic accept;
    logic is_lead;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_lead    = (i_in.in_byte == LEAD_D0) || (i_in.in_byte == LEAD_D1);

    always_comb begin
        n_lead_pending    = r_lead_pending;
        n_lead_d1         = r_lead_d1;
        o_push_valid      = 1'b0;
        o_push_entry.kind = K_SINGLE;
        o_push_entry.d1   = r_lead_d1;
        o_push_entry.data = i_in.in_byte;
        if (accept) begin
            if (r_lead_pending) begin
                n_lead_pending    = 1'b0;
                o_push_valid      = 1'b1;
                o_push_entry.kind = K_PAIR;
            end else if (is_lead && !i_in.end_of_stream) begin
                n_lead_pending = 1'b1;
                n_lead_d1      = (i_in.in_byte == LEAD_D1);
            end else begin
                o_push_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_d1      <= 1'b0;
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_d1      <= n_lead_d1;
        end
    end
endmodule

// ===== hdl/csbc_fifo.sv =====
// Short work queue between the front and back ends.
// Depends on csbc_pkg.
module csbc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  csbc_pkg::t_entry  i_push_entry,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output csbc_pkg::t_entry  o_pop_entry
);
    import csbc_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_entry  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// ===== hdl/csbc_back.sv =====
// Back end: shift registers, per-class Caesar shift and the registered output beat.
// Depends on csbc_pkg and csbc_out_if.
module csbc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [csbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_head_valid,
    output logic                              o_head_pop,
    input  csbc_pkg::t_entry                  i_head,
    csbc_out_if.source                        o_out
);
    import csbc_pkg::*;

    logic [LAT_W-1:0] r_lat;
    logic [CYR_W-1:0] r_cyr;
    logic [DIG_W-1:0] r_dig;
    logic             r_phase;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             load;
    logic             single;
    logic [7:0]       first_byte;
    logic [7:0]       second_byte;

    function automatic logic [4:0] mod26(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (r >= 6'd52) r = r - 6'd52;
        else if (r >= 6'd26) r = r - 6'd26;
        return r[4:0];
    endfunction

    function automatic logic [5:0] mod33(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (r >= 7'd66) r = r - 7'd66;
        else if (r >= 7'd33) r = r - 7'd33;
        return r[5:0];
    endfunction

    function automatic logic [3:0] mod10(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if (r >= 5'd20) r = r - 5'd20;
        else if (r >= 5'd10) r = r - 5'd10;
        return r[3:0];
    endfunction

    function automatic logic [7:0] cp_byte(input logic [5:0] p, input logic [7:0] base,
                                           input logic [7:0] yo);
        logic [7:0] r;
        if (p < 6'd6) r = base + 8'(p);
        else if (p == 6'd6) r = yo;
        else r = base + 8'(p) - 8'd1;
        return r;
    endfunction

    function automatic logic [7:0] shift_single(input logic [7:0] b,
                                                input logic [LAT_W-1:0] ls,
                                                input logic [CYR_W-1:0] cs,
                                                input logic [DIG_W-1:0] ds);
        logic [7:0] r;
        logic [5:0] pos;
        logic [3:0] d;
        logic [3:0] dm;
        r = b;
        pos = '0;
        d = '0;
        dm = '0;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = 8'h41 + 8'(mod26(6'(b - 8'h41) + 6'(ls)));
        end else if (b >= 8'h61 && b <= 8'h7A) begin
            r = 8'h61 + 8'(mod26(6'(b - 8'h61) + 6'(ls)));
        end else if (b == 8'hB8 || b >= 8'hE0) begin
            if (b == 8'hB8) pos = 6'd6;
            else if (b <= 8'hE5) pos = 6'(b - 8'hE0);
            else pos = 6'(b - 8'hE0 + 8'd1);
            r = cp_byte(mod33(7'(pos) + 7'(cs)), 8'hE0, 8'hB8);
        end else if (b == 8'hA8 || (b >= 8'hC0 && b <= 8'hDF)) begin
            if (b == 8'hA8) pos = 6'd6;
            else if (b <= 8'hC5) pos = 6'(b - 8'hC0);
            else pos = 6'(b - 8'hC0 + 8'd1);
            r = cp_byte(mod33(7'(pos) + 7'(cs)), 8'hC0, 8'hA8);
        end else if (b >= 8'h30 && b <= 8'h39) begin
            d = (b == 8'h30) ? 4'd9 : 4'(b - 8'h31);
            dm = mod10(5'(d) + 5'(ds));
            r = (dm == 4'd9) ? 8'h30 : 8'h31 + 8'(dm);
        end
        return r;
    endfunction

    always_comb begin
        logic [5:0] pos;
        logic       known;
        logic       upper;
        logic [5:0] p;
        pos = '0;
        known = 1'b0;
        upper = 1'b0;
        if (!i_head.d1) begin
            if (i_head.data >= 8'hB0 && i_head.data <= 8'hB5) begin
                pos = 6'(i_head.data - 8'hB0); known = 1'b1;
            end else if (i_head.data >= 8'hB6 && i_head.data <= 8'hBF) begin
                pos = 6'(i_head.data - 8'hB0 + 8'd1); known = 1'b1;
            end else if (i_head.data >= 8'h90 && i_head.data <= 8'h95) begin
                pos = 6'(i_head.data - 8'h90); known = 1'b1; upper = 1'b1;
            end else if (i_head.data == 8'h81) begin
                pos = 6'd6; known = 1'b1; upper = 1'b1;
            end else if (i_head.data >= 8'h96 && i_head.data <= 8'hAF) begin
                pos = 6'(i_head.data - 8'h90 + 8'd1); known = 1'b1; upper = 1'b1;
            end
        end else begin
            if (i_head.data == 8'h91) begin
                pos = 6'd6; known = 1'b1;
            end else if (i_head.data >= 8'h80 && i_head.data <= 8'h8F) begin
                pos = 6'(i_head.data - 8'h80 + 8'd17); known = 1'b1;
            end
        end
        p = mod33(7'(pos) + 7'(r_cyr));

        if (i_head.kind == K_SINGLE) begin
            first_byte  = shift_single(i_head.data, r_lat, r_cyr, r_dig);
            second_byte = first_byte;
        end else if (!known) begin
            first_byte  = cp_byte(mod33((i_head.d1 ? 7'd18 : 7'd17) + 7'(r_cyr)),
                                  8'hC0, 8'hA8);
            second_byte = shift_single(i_head.data, r_lat, r_cyr, r_dig);
        end else if (upper) begin
            first_byte  = LEAD_D0;
            second_byte = cp_byte(p, 8'h90, 8'h81);
        end else if (p < 6'd6) begin
            first_byte  = LEAD_D0;
            second_byte = 8'hB0 + 8'(p);
        end else if (p == 6'd6) begin
            first_byte  = LEAD_D1;
            second_byte = 8'h91;
        end else if (p <= 6'd16) begin
            first_byte  = LEAD_D0;
            second_byte = 8'hB0 + 8'(p) - 8'd1;
        end else begin
            first_byte  = LEAD_D1;
            second_byte = 8'h80 + 8'(p) - 8'd17;
        end
    end

    assign single     = (i_head.kind == K_SINGLE);
    assign load       = i_head_valid && (!r_out_valid || o_out.ready);
    assign o_head_pop = load && (single || r_phase);

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= '0;
            r_cyr <= '0;
            r_dig <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LATIN:    r_lat <= i_cfg_data[LAT_W-1:0];
                CFG_CYRILLIC: r_cyr <= i_cfg_data[CYR_W-1:0];
                CFG_DIGIT:    r_dig <= i_cfg_data[DIG_W-1:0];
                default:      r_lat <= r_lat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_phase     <= !(single || r_phase);
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= (r_phase && !single) ? second_byte : first_byte;
            r_out_last <= single || r_phase;
        end
    end
endmodule

// ===== tb/sv/caesar_shift_byte_cipher_top_tb.sv =====
// Self-checking testbench for caesar_shift_byte_cipher_top: a directed table, then random
// byte streams under several shift settings and handshake idle/stall mixes.
// Depends on csbc_pkg, csbc_in_if, csbc_out_if and the cipher RTL.
module caesar_shift_byte_cipher_top_tb;
    import csbc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_BEATS   = 200;
    localparam int N_PHASES      = 8;
    localparam int N_DIR         = 25;

    typedef enum logic {
        ROW_BEAT,
        ROW_SHIFTS
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] in_byte;
        logic       eos;
        logic       typed;
        logic [1:0] n_out;
        logic [7:0] out0;
        logic [7:0] out1;
        logic [5:0] lat;
        logic [5:0] cyr;
        logic [5:0] dig;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } cipher_beat_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    csbc_in_if  in_if ();
    csbc_out_if out_if ();

    caesar_shift_byte_cipher_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cipher_beat_t expected_beats[$];
    int           errors;
    int           quiet_cycles;
    int           src_idle_pct;
    int           snk_stall_pct;
    int           hold_req;

    int           shift_lat;
    int           shift_cyr;
    int           shift_dig;
    bit           lead_held;
    bit           lead_d1;

    stim_row_t dir_rows [N_DIR] = '{
        '{ROW_BEAT,   8'h41, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h7A, 1'b0, 1'b1, 2'd1, 8'h7A, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h30, 1'b0, 1'b1, 2'd1, 8'h30, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h39, 1'b0, 1'b1, 2'd1, 8'h39, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hFF, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hB8, 1'b0, 1'b1, 2'd1, 8'hB8, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hA8, 1'b0, 1'b1, 2'd1, 8'hA8, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hB0, 1'b0, 1'b1, 2'd2, 8'hD0, 8'hB0, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h91, 1'b0, 1'b1, 2'd2, 8'hD1, 8'h91, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h81, 1'b0, 1'b1, 2'd2, 8'hD0, 8'h81, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h41, 1'b0, 1'b1, 2'd2, 8'hD1, 8'h41, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD0, 1'b0, 1'b1, 2'd2, 8'hD0, 8'hD0, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD1, 1'b1, 1'b1, 2'd1, 8'hD1, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_SHIFTS, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 6'h3F, 6'h3F, 6'h3F},
        '{ROW_BEAT,   8'h5A, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h30, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hDF, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'hD1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0},
        '{ROW_BEAT,   8'h8F, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 6'd0,  6'd0,  6'd0}
    };

    function automatic int cp_pos(input logic [7:0] b, input int base, input int yo);
        int v;
        v = b;
        if (v == yo) return 6;
        if (v >= base && v <= base + 5) return v - base;
        if (v >= base + 6 && v <= base + 31) return v - base + 1;
        return -1;
    endfunction

    function automatic logic [7:0] cp_byte(input int p, input int base, input int yo);
        if (p < 6) return 8'(base + p);
        if (p == 6) return 8'(yo);
        return 8'(base + p - 1);
    endfunction

    function automatic logic [7:0] shift_one(input logic [7:0] b);
        int v;
        int p;
        int d;
        v = b;
        if (v >= "A" && v <= "Z") return 8'("A" + (v - "A" + shift_lat) % 26);
        if (v >= "a" && v <= "z") return 8'("a" + (v - "a" + shift_lat) % 26);
        p = cp_pos(b, 'hE0, 'hB8);
        if (p >= 0) return cp_byte((p + shift_cyr) % 33, 'hE0, 'hB8);
        p = cp_pos(b, 'hC0, 'hA8);
        if (p >= 0) return cp_byte((p + shift_cyr) % 33, 'hC0, 'hA8);
        if (v >= "0" && v <= "9") begin
            d = (v == "0") ? 9 : v - "1";
            d = (d + shift_dig) % 10;
            return (d == 9) ? 8'("0") : 8'("1" + d);
        end
        return b;
    endfunction

    // Advance the lead state and return how many output beats this byte yields.
    function automatic int encipher(input logic [7:0] b, input logic eos,
                                    output logic [7:0] o0, output logic [7:0] o1);
        int  v;
        int  pos;
        int  p;
        bit  upper;
        v = b;
        o0 = 8'h00;
        o1 = 8'h00;
        if (!lead_held) begin
            if ((b == LEAD_D0 || b == LEAD_D1) && !eos) begin
                lead_held = 1'b1;
                lead_d1 = (b == LEAD_D1);
                return 0;
            end
            o0 = shift_one(b);
            return 1;
        end
        lead_held = 1'b0;
        pos = -1;
        upper = 1'b0;
        if (!lead_d1) begin
            if (v >= 'hB0 && v <= 'hB5) pos = v - 'hB0;
            else if (v >= 'hB6 && v <= 'hBF) pos = v - 'hB0 + 1;
            else if (v >= 'h90 && v <= 'h95) begin pos = v - 'h90; upper = 1'b1; end
            else if (v == 'h81) begin pos = 6; upper = 1'b1; end
            else if (v >= 'h96 && v <= 'hAF) begin pos = v - 'h90 + 1; upper = 1'b1; end
        end else begin
            if (v == 'h91) pos = 6;
            else if (v >= 'h80 && v <= 'h8F) pos = v - 'h80 + 17;
        end
        if (pos >= 0) begin
            p = (pos + shift_cyr) % 33;
            if (upper) begin
                o0 = LEAD_D0;
                o1 = (p < 6) ? 8'('h90 + p) : (p == 6) ? 8'h81 : 8'('h90 + p - 1);
            end else if (p < 6) begin
                o0 = LEAD_D0;
                o1 = 8'('hB0 + p);
            end else if (p == 6) begin
                o0 = LEAD_D1;
                o1 = 8'h91;
            end else if (p <= 16) begin
                o0 = LEAD_D0;
                o1 = 8'('hB0 + p - 1);
            end else begin
                o0 = LEAD_D1;
                o1 = 8'('h80 + p - 17);
            end
            return 2;
        end
        o0 = cp_byte(((lead_d1 ? 18 : 17) + shift_cyr) % 33, 'hC0, 'hA8);
        o1 = shift_one(b);
        return 2;
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic eos, input bit typed = 1'b0,
                             input int n_typed = 0, input logic [7:0] t0 = 8'h00,
                             input logic [7:0] t1 = 8'h00);
        int         gap;
        int         n;
        logic [7:0] o0;
        logic [7:0] o1;
        gap = 0;
        while (src_idle_pct > 0 && gap < 40 && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.in_byte       <= b;
        in_if.end_of_stream <= eos;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        n = encipher(b, eos, o0, o1);
        if (typed) begin
            n  = n_typed;
            o0 = t0;
            o1 = t1;
        end
        if (n == 1) expected_beats.push_back('{o0, 1'b1});
        if (n == 2) begin
            expected_beats.push_back('{o0, 1'b0});
            expected_beats.push_back('{o1, 1'b1});
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
    endtask

    // Complete any held lead, then let the pipeline go quiet before a register write.
    task automatic settle();
        if (lead_held) send_beat(8'h20, 1'b0);
        drain_results();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_shifts(input logic [5:0] lat, input logic [5:0] cyr,
                               input logic [5:0] dig);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LATIN;
        i_cfg_data <= lat;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CYRILLIC;
        i_cfg_data <= cyr;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DIGIT;
        i_cfg_data <= dig;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shift_lat = int'(lat[LAT_W-1:0]);
        shift_cyr = int'(cyr[CYR_W-1:0]);
        shift_dig = int'(dig[DIG_W-1:0]);
    endtask

    // Mostly well-formed text: UTF-8 Cyrillic pairs, cp1251 letters, Latin, digits,
    // plus raw bytes, broken pairs and leads that end the stream.
    task automatic send_random_unit(inout int beats);
        int         r;
        int         p;
        logic [7:0] lead;
        logic [7:0] tail;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            p = $urandom_range(0, 32);
            if ($urandom_range(0, 1) == 1) begin
                lead = LEAD_D0;
                tail = (p < 6) ? 8'('h90 + p) : (p == 6) ? 8'h81 : 8'('h90 + p - 1);
            end else if (p < 6) begin
                lead = LEAD_D0;
                tail = 8'('hB0 + p);
            end else if (p == 6) begin
                lead = LEAD_D1;
                tail = 8'h91;
            end else if (p <= 16) begin
                lead = LEAD_D0;
                tail = 8'('hB0 + p - 1);
            end else begin
                lead = LEAD_D1;
                tail = 8'('h80 + p - 17);
            end
            send_beat(lead, 1'b0);
            send_beat(tail, $urandom_range(0, 15) == 0);
            beats += 2;
        end else if (r < 95) begin
            if (r < 52) tail = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1)
                               ? 8'hA8 : 8'hB8) : 8'($urandom_range('hC0, 'hFF));
            else if (r < 64) tail = ($urandom_range(0, 1) == 1)
                               ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z"));
            else if (r < 74) tail = 8'($urandom_range("0", "9"));
            else if (r < 86) tail = 8'($urandom_range(0, 255));
            else begin
                send_beat(($urandom_range(0, 1) == 1) ? LEAD_D1 : LEAD_D0, 1'b0);
                beats++;
                tail = 8'($urandom_range(0, 255));
            end
            send_beat(tail, $urandom_range(0, 15) == 0);
            beats++;
        end else begin
            send_beat(($urandom_range(0, 1) == 1) ? LEAD_D1 : LEAD_D0, 1'b1);
            beats++;
        end
    endtask

    always @(posedge i_clk) begin
        cipher_beat_t want;
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat out_byte=%02h run_last=%0b",
                         $time, out_if.out_byte, out_if.run_last);
            end else begin
                want = expected_beats.pop_front();
                if (out_if.out_byte !== want.out_byte) begin
                    errors++;
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, want.out_byte, out_if.out_byte);
                end
                if (out_if.run_last !== want.run_last) begin
                    errors++;
                    $display("%0t: run_last expected %0b got %0b",
                             $time, want.run_last, out_if.run_last);
                end
            end
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    initial begin
        int beats;
        errors        = 0;
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 0;
        shift_lat     = 0;
        shift_cyr     = 0;
        shift_dig     = 0;
        lead_held     = 1'b0;
        lead_d1       = 1'b0;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_LATIN;
        i_cfg_data          <= '0;
        in_if.valid         <= 1'b0;
        in_if.in_byte       <= 8'h00;
        in_if.end_of_stream <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].kind == ROW_SHIFTS) begin
                settle();
                load_shifts(dir_rows[i].lat, dir_rows[i].cyr, dir_rows[i].dig);
            end else begin
                send_beat(dir_rows[i].in_byte, dir_rows[i].eos, dir_rows[i].typed,
                          dir_rows[i].n_out, dir_rows[i].out0, dir_rows[i].out1);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: load_shifts(6'd25, 6'd32, 6'd9);
                1: load_shifts(6'd0, 6'd0, 6'd0);
                2: load_shifts(6'h3F, 6'h3F, 6'h3F);
                default: load_shifts(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                     6'($urandom_range(0, 63)));
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
                default: begin src_idle_pct = 17; snk_stall_pct = 17; end
            endcase
            beats = 0;
            while (beats < PHASE_BEATS) begin
                if (ph % 4 == 0 && beats >= 60 && beats < 62) hold_req = 60;
                if (beats >= 120 && beats < 122) drain_results();
                send_random_unit(beats);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (expected_beats.size() != 0) begin
            errors++;
            $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
